@@ rtl/afs_pkg.sv @@
package afs_pkg;

  localparam int unsigned MAC_BYTES       = 12;
  localparam int unsigned OUTER_HDR_LEN   = 14;
  localparam logic [15:0] OUTER_TYPE_RESET = 16'h0642;
  localparam int unsigned IN_FIFO_DEPTH   = 8;

  // One input byte of the aggregate frame as it sits in the input queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

endpackage

@@ rtl/afs_in_if.sv @@
interface afs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

@@ rtl/afs_out_if.sv @@
interface afs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       sub_last;
  logic       truncated;

  modport source (output valid, output out_byte, output sub_last, output truncated,
                  input ready);
  modport sink   (input valid, input out_byte, input sub_last, input truncated,
                  output ready);
endinterface

@@ rtl/afs_cfg_if.sv @@
interface afs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] outer_ether_type;

  modport source (output valid, output outer_ether_type, input ready);
  modport sink   (input valid, input outer_ether_type, output ready);
endinterface

@@ rtl/aggregate_frame_splitter_core.sv @@
// An accepted input byte is stored in the input queue, then in the output register.
// One input transaction per cycle while the queue has room; one result transaction per cycle
// while ready is high, set by the single output register, which sends 14-byte header bursts.
// The input queue (IN_FIFO_DEPTH entries) keeps taking bytes while a burst drains.
// Reset (rst_n, synchronous, active low) clears the queue, parser state and output register,
// and loads the outer EtherType register with 0x0642; the MAC store is not cleared.
module aggregate_frame_splitter_core #(
  parameter int unsigned IN_FIFO_DEPTH = afs_pkg::IN_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  afs_in_if.sink    in_chan,
  afs_out_if.source out_chan,
  afs_cfg_if.sink   cfg_chan
);

  // Parser phase: outer header, sub-frame header, or sub-frame payload.
  typedef enum logic [1:0] {
    PH_OUTER,
    PH_SUBHDR,
    PH_PAYLOAD
  } phase_t;

  // Byte positions inside the 4-byte sub-frame header.
  localparam logic [1:0] SH_LEN_HI  = 2'd0;
  localparam logic [1:0] SH_LEN_LO  = 2'd1;
  localparam logic [1:0] SH_TYPE_HI = 2'd2;
  localparam logic [1:0] SH_TYPE_LO = 2'd3;

  localparam logic [3:0] MAC_LAST_IDX  = 4'(afs_pkg::MAC_BYTES - 1);
  localparam logic [3:0] TYPE_HI_IDX   = 4'(afs_pkg::MAC_BYTES);
  localparam logic [3:0] HDR_LAST_IDX  = 4'(afs_pkg::OUTER_HDR_LEN - 1);

  // ---------------------------------------------------------------------------
  // Configuration register. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [15:0] outer_type_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_type_r <= afs_pkg::OUTER_TYPE_RESET;
    end else if (cfg_chan.valid) begin
      outer_type_r <= cfg_chan.outer_ether_type;
    end
  end

  // ---------------------------------------------------------------------------
  // Input queue. It decouples the link from the output, which stalls the parser
  // for the length of every rebuilt header burst.
  // ---------------------------------------------------------------------------
  afs_pkg::in_item_t wr_item;
  afs_pkg::in_item_t rd_item;
  logic              rd_valid;
  logic              rd_pop;

  assign wr_item.data_byte  = in_chan.data_byte;
  assign wr_item.frame_last = in_chan.frame_last;

  afs_fifo #(
    .DEPTH (IN_FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_chan.valid),
    .wr_ready (in_chan.ready),
    .wr_data  (wr_item),
    .rd_valid (rd_valid),
    .rd_pop   (rd_pop),
    .rd_data  (rd_item)
  );

  // ---------------------------------------------------------------------------
  // Parser state.
  // ---------------------------------------------------------------------------
  phase_t      phase_r,    phase_nxt;
  logic [3:0]  hdr_pos_r,  hdr_pos_nxt;
  logic [7:0]  type_hi_r,  type_hi_nxt;
  logic [15:0] sub_len_r,  sub_len_nxt;
  logic [15:0] remain_r,   remain_nxt;
  logic [15:0] sub_type_r, sub_type_nxt;
  logic        drop_r,     drop_nxt;
  logic [7:0]  mac_r [afs_pkg::MAC_BYTES];
  logic        mac_we;

  // Header burst: after the last sub-header byte the 12 MAC bytes and the two type
  // bytes go out one per cycle while the output is ready. The first MAC byte enters the
  // output register as the sub-header byte is popped; burst_idx_r then walks positions 1..13.
  logic        burst_r,       burst_nxt;
  logic [3:0]  burst_idx_r,   burst_idx_nxt;
  logic        burst_last_r,  burst_last_nxt;
  logic        burst_trunc_r, burst_trunc_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r,  out_byte_nxt;
  logic        sub_last_r,  sub_last_nxt;
  logic        trunc_r,     trunc_nxt;

  logic        proc_go;
  logic [7:0]  b;
  logic        fl;
  logic [1:0]  sh_pos;
  logic [15:0] remain_dec;
  logic        pl_done;
  logic        sh_empty;

  // The parser advances whenever the output register is free or being emptied.
  assign proc_go    = !out_valid_r || out_chan.ready;
  assign rd_pop     = proc_go && !burst_r;
  assign b          = rd_item.data_byte;
  assign fl         = rd_item.frame_last;
  assign sh_pos     = hdr_pos_r[1:0];
  assign remain_dec = remain_r - 16'd1;
  assign pl_done    = (remain_dec == 16'd0);
  assign sh_empty   = (sub_len_r == 16'd0);

  always_comb begin
    phase_nxt       = phase_r;
    hdr_pos_nxt     = hdr_pos_r;
    type_hi_nxt     = type_hi_r;
    sub_len_nxt     = sub_len_r;
    remain_nxt      = remain_r;
    sub_type_nxt    = sub_type_r;
    drop_nxt        = drop_r;
    mac_we          = 1'b0;
    burst_nxt       = burst_r;
    burst_idx_nxt   = burst_idx_r;
    burst_last_nxt  = burst_last_r;
    burst_trunc_nxt = burst_trunc_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_byte_nxt    = out_byte_r;
    sub_last_nxt    = sub_last_r;
    trunc_nxt       = trunc_r;

    if (proc_go && burst_r) begin
      // Continue the rebuilt header from the stored MAC bytes and sub-frame type.
      out_valid_nxt = 1'b1;
      sub_last_nxt  = 1'b0;
      trunc_nxt     = 1'b0;
      if (burst_idx_r <= MAC_LAST_IDX) begin
        out_byte_nxt = mac_r[burst_idx_r];
      end else if (burst_idx_r == TYPE_HI_IDX) begin
        out_byte_nxt = sub_type_r[15:8];
      end else begin
        out_byte_nxt = sub_type_r[7:0];
        sub_last_nxt = burst_last_r;
        trunc_nxt    = burst_trunc_r;
      end
      if (burst_idx_r == HDR_LAST_IDX) begin
        burst_nxt = 1'b0;
      end
      burst_idx_nxt = burst_idx_r + 4'd1;
    end else if (rd_pop && rd_valid) begin
      if (drop_r) begin
        // The rest of a rejected frame is discarded.
      end else begin
        unique case (phase_r)
          PH_OUTER: begin
            if (hdr_pos_r <= MAC_LAST_IDX) begin
              mac_we = 1'b1;
            end else if (hdr_pos_r == TYPE_HI_IDX) begin
              type_hi_nxt = b;
            end else if ({type_hi_r, b} != outer_type_r) begin
              drop_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SUBHDR;
            end
            hdr_pos_nxt = (hdr_pos_r < HDR_LAST_IDX) ? hdr_pos_r + 4'd1 : 4'd0;
            if (phase_nxt == PH_SUBHDR) begin
              hdr_pos_nxt = 4'd0;
            end
          end
          PH_SUBHDR: begin
            hdr_pos_nxt = {2'b00, sh_pos + 2'd1};
            unique case (sh_pos)
              SH_LEN_HI: begin
                sub_len_nxt = {b, 8'h00};
              end
              SH_LEN_LO: begin
                sub_len_nxt = {sub_len_r[15:8], b};
              end
              SH_TYPE_HI: begin
                type_hi_nxt = b;
              end
              SH_TYPE_LO: begin
                // Sub-header complete: start the 14-byte header burst.
                sub_type_nxt    = {type_hi_r, b};
                remain_nxt      = sub_len_r;
                hdr_pos_nxt     = 4'd0;
                phase_nxt       = sh_empty ? PH_SUBHDR : PH_PAYLOAD;
                burst_nxt       = 1'b1;
                burst_idx_nxt   = 4'd1;
                burst_last_nxt  = sh_empty || fl;
                burst_trunc_nxt = !sh_empty && fl;
                out_valid_nxt   = 1'b1;
                out_byte_nxt    = mac_r[0];
                sub_last_nxt    = 1'b0;
                trunc_nxt       = 1'b0;
              end
              default: begin
              end
            endcase
          end
          PH_PAYLOAD: begin
            // Payload bytes pass straight through; an early frame end marks a cut payload.
            remain_nxt    = remain_dec;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = b;
            sub_last_nxt  = pl_done || fl;
            trunc_nxt     = !pl_done && fl;
            if (pl_done) begin
              phase_nxt   = PH_SUBHDR;
              hdr_pos_nxt = 4'd0;
            end
          end
          default: begin
            phase_nxt = PH_OUTER;
          end
        endcase
      end
      // The end of the aggregate frame always returns the parser to the outer header.
      if (fl) begin
        phase_nxt   = PH_OUTER;
        hdr_pos_nxt = 4'd0;
        drop_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OUTER;
      hdr_pos_r     <= 4'd0;
      type_hi_r     <= 8'd0;
      sub_len_r     <= 16'd0;
      remain_r      <= 16'd0;
      sub_type_r    <= 16'd0;
      drop_r        <= 1'b0;
      burst_r       <= 1'b0;
      burst_idx_r   <= 4'd0;
      burst_last_r  <= 1'b0;
      burst_trunc_r <= 1'b0;
      out_valid_r   <= 1'b0;
      out_byte_r    <= 8'd0;
      sub_last_r    <= 1'b0;
      trunc_r       <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      hdr_pos_r     <= hdr_pos_nxt;
      type_hi_r     <= type_hi_nxt;
      sub_len_r     <= sub_len_nxt;
      remain_r      <= remain_nxt;
      sub_type_r    <= sub_type_nxt;
      drop_r        <= drop_nxt;
      burst_r       <= burst_nxt;
      burst_idx_r   <= burst_idx_nxt;
      burst_last_r  <= burst_last_nxt;
      burst_trunc_r <= burst_trunc_nxt;
      out_valid_r   <= out_valid_nxt;
      out_byte_r    <= out_byte_nxt;
      sub_last_r    <= sub_last_nxt;
      trunc_r       <= trunc_nxt;
    end
  end

  // The MAC store carries no reset; every frame writes it before reading it.
  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_r[hdr_pos_r] <= b;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.sub_last  = sub_last_r;
  assign out_chan.truncated = trunc_r;

endmodule

@@ rtl/afs_fifo.sv @@
module afs_fifo #(
  parameter int unsigned DEPTH = afs_pkg::IN_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  afs_pkg::in_item_t wr_data,
  output logic              rd_valid,
  input  logic              rd_pop,
  output afs_pkg::in_item_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  afs_pkg::in_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ tb/sv/aggregate_frame_splitter_core_tb.sv @@
`timescale 1ns / 1ps

module aggregate_frame_splitter_core_tb;

  // Where the parser stands inside the aggregate frame.
  typedef enum logic [1:0] {
    AWAIT_OUTER,
    IN_SUB_HEADER,
    IN_PAYLOAD
  } parse_phase_t;

  // How the last sub-frame of a random frame ends.
  typedef enum logic [1:0] {
    END_CLEAN,
    END_CUT_PAYLOAD,
    END_NO_PAYLOAD,
    END_CUT_SUB_HEADER
  } frame_end_t;

  // One byte of a rebuilt sub-frame as the block should emit it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       sub_last;
    logic       truncated;
  } rebuilt_byte_t;

  // The scoreboard carries its own copy of the parser state and the outer
  // EtherType register. Each accepted input byte is run through the same
  // rules as the block, and the bytes that the block must emit for it are
  // queued in order. Each result transaction is compared with the oldest one.
  class subframe_scoreboard;
    logic [15:0]   outer_type;
    parse_phase_t  phase;
    logic [3:0]    hdr_pos;
    logic [7:0]    mac_bytes[afs_pkg::MAC_BYTES];
    logic [7:0]    type_hi;
    logic [15:0]   sub_len;
    logic [15:0]   remaining;
    logic          dropping;
    rebuilt_byte_t rebuilt_q[$];
    int            failures;

    function new();
      outer_type = afs_pkg::OUTER_TYPE_RESET;
      type_hi    = '0;
      sub_len    = '0;
      remaining  = '0;
      failures   = 0;
      for (int i = 0; i < afs_pkg::MAC_BYTES; i++) mac_bytes[i] = '0;
      restart();
    endfunction

    function void restart();
      phase    = AWAIT_OUTER;
      hdr_pos  = '0;
      dropping = 1'b0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      failures++;
    endfunction

    function void push_rebuilt(logic [7:0] b, logic last, logic trunc);
      rebuilt_byte_t r;
      r.out_byte  = b;
      r.sub_last  = last;
      r.truncated = trunc;
      rebuilt_q.push_back(r);
    endfunction

    function int pending();
      return rebuilt_q.size();
    endfunction

    // Called for every accepted input transaction.
    function void accept_byte(logic [7:0] b, logic frame_last);
      logic [3:0] pos;
      logic       empty;
      logic       done;
      // A rejected frame is swallowed until its last byte.
      if (dropping) begin
        if (frame_last) restart();
        return;
      end
      case (phase)
        AWAIT_OUTER: begin
          pos = hdr_pos;
          if (pos < afs_pkg::MAC_BYTES) begin
            mac_bytes[pos] = b;
          end else if (pos == afs_pkg::MAC_BYTES) begin
            type_hi = b;
          end else if ({type_hi, b} != outer_type) begin
            dropping = 1'b1;
          end else begin
            phase = IN_SUB_HEADER;
          end
          hdr_pos = (pos < afs_pkg::OUTER_HDR_LEN - 1) ? pos + 4'd1 : 4'd0;
          if (phase == IN_SUB_HEADER) hdr_pos = '0;
        end
        IN_SUB_HEADER: begin
          pos = {2'b00, hdr_pos[1:0]};
          case (pos[1:0])
            2'd0: sub_len = {b, 8'h00};
            2'd1: sub_len = sub_len | {8'h00, b};
            2'd2: type_hi = b;
            default: begin
              // The sub-header is complete: the whole rebuilt header goes out.
              remaining = sub_len;
              empty     = (sub_len == 16'd0);
              for (int i = 0; i < afs_pkg::MAC_BYTES; i++)
                push_rebuilt(mac_bytes[i], 1'b0, 1'b0);
              push_rebuilt(type_hi, 1'b0, 1'b0);
              push_rebuilt(b, empty || frame_last, !empty && frame_last);
              phase = empty ? IN_SUB_HEADER : IN_PAYLOAD;
            end
          endcase
          hdr_pos = (pos[1:0] == 2'd3) ? 4'd0 : pos + 4'd1;
        end
        default: begin
          remaining = remaining - 16'd1;
          done      = (remaining == 16'd0);
          push_rebuilt(b, done || frame_last, !done && frame_last);
          if (done) begin
            phase   = IN_SUB_HEADER;
            hdr_pos = '0;
          end
        end
      endcase
      if (frame_last) restart();
    endfunction

    // Called for every accepted result transaction.
    function void check_rebuilt(logic [7:0] b, logic last, logic trunc);
      rebuilt_byte_t want;
      if (rebuilt_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h last %b trunc %b", b, last, trunc));
        return;
      end
      want = rebuilt_q.pop_front();
      if (b !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", b, want.out_byte));
      if (last !== want.sub_last)
        report($sformatf("sub_last %b, want %b (byte %02h)", last, want.sub_last, b));
      if (trunc !== want.truncated)
        report($sformatf("truncated %b, want %b (byte %02h)", trunc, want.truncated, b));
    endfunction
  endclass

  // Settle time after the last expected byte: the pass through the queue and
  // output register, plus a full input queue that may still hold bytes that emit nothing.
  localparam int unsigned DRAIN_PAD = 40;
  // Long receiver hold-off used to fill the input queue and stall the sender.
  localparam int unsigned RX_HOLD_CYCLES = 300;
  // Random bytes sent under each register setting.
  localparam int unsigned PHASE_BYTES = 20;

  logic clk;
  logic rst_n;

  afs_in_if  in_if ();
  afs_out_if out_if ();
  afs_cfg_if cfg_if ();

  aggregate_frame_splitter_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  subframe_scoreboard sb = new();

  // Bytes of the frame being assembled for the sender.
  logic [7:0] frame_q[$];
  // Per-side switches for stretches without idle cycles.
  bit tx_no_idle;
  bit rx_no_idle;
  // Receiver hold-off request, consumed by the receiver process.
  int rx_hold;
  int bytes_sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every input of the block is driven from time zero. Reset is held low
  // at the start and is never asserted again.
  initial begin
    rst_n                   <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.data_byte         <= '0;
    in_if.frame_last        <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.outer_ether_type <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Offer one byte. A gap of zero keeps valid high from the previous
  // transaction, so valid is never lowered and raised in the same step.
  // Handshake signals are sampled at the clock edge, before the block's
  // own updates for that edge take effect.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.frame_last <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.accept_byte(b, last);
    bytes_sent++;
  endtask

  // Send the assembled frame with frame_last on its final byte.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic push_outer_header(input logic [15:0] hdr_type);
    repeat (afs_pkg::MAC_BYTES) frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(hdr_type[15:8]);
    frame_q.push_back(hdr_type[7:0]);
  endtask

  task automatic push_sub_header(input logic [15:0] len, input logic [15:0] sub_type);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(sub_type[15:8]);
    frame_q.push_back(sub_type[7:0]);
  endtask

  task automatic push_random_bytes(input int n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Stop offering input and wait until every expected result has come, then
  // give the block time to consume whatever silent bytes it still holds.
  // The wait never ends in the step where it began, so a following transaction
  // never raises valid in the step where it was lowered.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_outer_type(input logic [15:0] value);
    cfg_if.valid            <= 1'b1;
    cfg_if.outer_ether_type <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.outer_type = value;
  endtask

  // One random frame. Most are well formed with random content, so that
  // the parser gets past the outer header; the rest carry a wrong EtherType
  // or are plain noise. The last sub-frame may end cleanly or be cut short.
  task automatic send_random_frame();
    int         kind;
    int         subs;
    int         len;
    int         pick;
    frame_end_t how;
    kind       = $urandom_range(0, 9);
    tx_no_idle = ($urandom_range(0, 3) == 0);
    rx_no_idle = ($urandom_range(0, 3) == 0);
    if (kind == 0) begin
      push_random_bytes($urandom_range(1, 20));
    end else begin
      push_outer_header(kind == 1 ? sb.outer_type ^ (16'h0001 << $urandom_range(0, 15))
                                  : sb.outer_type);
      subs = $urandom_range(1, 3);
      for (int s = 0; s < subs; s++) begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        pick = $urandom_range(0, 5);
        how  = END_CLEAN;
        if (s == subs - 1) begin
          case (pick)
            3: how = END_CUT_PAYLOAD;
            4: how = END_NO_PAYLOAD;
            5: how = END_CUT_SUB_HEADER;
            default: how = END_CLEAN;
          endcase
        end
        case (how)
          END_CUT_PAYLOAD: begin
            // Now and then a huge length, so the upper length bits toggle.
            if ($urandom_range(0, 3) == 0) len = $urandom_range(256, 65535);
            else if (len < 2) len = 2;
            push_sub_header(16'(len), 16'($urandom_range(0, 65535)));
            push_random_bytes($urandom_range(1, len < 20 ? len - 1 : 19));
          end
          END_NO_PAYLOAD: begin
            push_sub_header(16'(len == 0 ? 1 : len), 16'($urandom_range(0, 65535)));
          end
          END_CUT_SUB_HEADER: begin
            push_sub_header(16'(len), 16'($urandom_range(0, 65535)));
            push_random_bytes(len);
            push_random_bytes($urandom_range(1, 3));
          end
          default: begin
            push_sub_header(16'(len), 16'($urandom_range(0, 65535)));
            push_random_bytes(len);
          end
        endcase
      end
    end
    send_frame();
  endtask

  // Run random frames until this register setting has seen enough bytes.
  task automatic run_random_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) send_random_frame();
  endtask

  // Receiver: for every result it waits a random number of cycles with
  // ready low, unless a stretch without idling is on. A hold-off request
  // from the stimulus keeps ready low for a long, counted stretch.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_rebuilt(out_if.out_byte, out_if.sub_last, out_if.truncated);
    end
  end

  // Main stimulus.
  initial begin
    logic [15:0] settings[2];
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    rx_hold    = 0;
    bytes_sent = 0;
    settings   = '{16'hFFFF, 16'($urandom_range(0, 65535))};

    while (rst_n !== 1'b1) @(posedge clk);
    @(posedge clk);

    // Directed frames under the reset value of the register.
    // A one-byte frame and a short frame are dropped silently.
    push_random_bytes(1);
    send_frame();
    push_random_bytes(7);
    send_frame();
    // A header-only frame gives no output.
    push_outer_header(afs_pkg::OUTER_TYPE_RESET);
    send_frame();
    // A wrong outer type drops the whole frame, sub-frames included.
    push_outer_header(16'h0643);
    push_sub_header(16'd0, 16'hFFFF);
    send_frame();
    // Zero length, then a full payload, then a payload cut short.
    push_outer_header(afs_pkg::OUTER_TYPE_RESET);
    push_sub_header(16'd0, 16'h0000);
    push_sub_header(16'd3, 16'hFFFF);
    push_random_bytes(3);
    push_sub_header(16'd2, 16'h0800);
    push_random_bytes(1);
    send_frame();
    // The frame ends right after a sub-header with a nonzero length.
    push_outer_header(afs_pkg::OUTER_TYPE_RESET);
    push_sub_header(16'd4, 16'h86DD);
    send_frame();
    // One full sub-frame, then a sub-header cut after two bytes.
    push_outer_header(afs_pkg::OUTER_TYPE_RESET);
    push_sub_header(16'd1, 16'h0806);
    push_random_bytes(1);
    push_random_bytes(2);
    send_frame();
    // Largest length, payload cut after two bytes.
    push_outer_header(afs_pkg::OUTER_TYPE_RESET);
    push_sub_header(16'hFFFF, 16'h1234);
    push_random_bytes(2);
    send_frame();

    // Back pressure: the receiver holds off while a frame of six empty
    // sub-frames streams in without gaps. The input queue fills and the
    // block has to stall its input.
    tx_no_idle = 1'b1;
    rx_hold    = RX_HOLD_CYCLES;
    push_outer_header(afs_pkg::OUTER_TYPE_RESET);
    repeat (6) push_sub_header(16'd0, 16'($urandom_range(0, 65535)));
    send_frame();
    // The sender pauses here until every expected byte has been taken.
    settle();

    // Further register settings, each written while the block is idle.
    foreach (settings[i]) begin
      settle();
      write_outer_type(settings[i]);
      run_random_phase();
    end

    settle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected bytes never came", sb.pending()));
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
